/* sv/rgb555_fire_pixel_classifier_top_defines.svh */
// Assertion macros for the fire pixel classifier.
// Depends on a clk and an arst_n signal in the scope of each use.
`ifndef RGB555_FIRE_PIXEL_CLASSIFIER_TOP_DEFINES_SVH
`define RGB555_FIRE_PIXEL_CLASSIFIER_TOP_DEFINES_SVH

// Checked on every rising edge outside reset.
`define RGBF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define RGBF_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/rgbfire_pkg.sv */
// Shared widths, register indexes and types for the fire pixel classifier.
// No dependencies.
package rgbfire_pkg;

	localparam int CH_W       = 8;
	localparam int CNT_W      = 21;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 21;

	localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(1048576);
	localparam int FRAME_PIXELS_DEF = 307200;

	localparam logic [CFG_IDX_W-1:0] REG_DARK_THR  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_RED_MIN   = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_GREEN_MIN = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_BLUE_MIN  = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_RED_MAX   = CFG_IDX_W'(4);
	localparam logic [CFG_IDX_W-1:0] REG_GREEN_MAX = CFG_IDX_W'(5);
	localparam logic [CFG_IDX_W-1:0] REG_BLUE_MAX  = CFG_IDX_W'(6);
	localparam logic [CFG_IDX_W-1:0] REG_DARK_LIM  = CFG_IDX_W'(7);

	typedef struct packed {
		logic [CH_W-1:0]  dark_threshold;
		logic [CH_W-1:0]  red_min;
		logic [CH_W-1:0]  green_min;
		logic [CH_W-1:0]  blue_min;
		logic [CH_W-1:0]  red_max;
		logic [CH_W-1:0]  green_max;
		logic [CH_W-1:0]  blue_max;
		logic [CNT_W-1:0] dark_limit;
	} cfg_t;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic            fire;
		logic            dark;
	} cls_t;

	typedef struct packed {
		logic [CNT_W-1:0] dark_total;
		logic [CNT_W-1:0] fire_total;
		logic             unusable;
	} stats_t;

endpackage

/* sv/rgbfire_cfg.sv */
// Configuration register file: thresholds, fire bounds and dark limit.
// Depends on rgbfire_pkg.
module rgbfire_cfg
	import rgbfire_pkg::*;
#(
	parameter int FRAME_PIXELS = FRAME_PIXELS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output cfg_t                  cfg
);

	localparam logic [CNT_W-1:0] DARK_LIMIT_RST = CNT_W'((FRAME_PIXELS * 2) / 5);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dark_threshold <= CH_W'(27);
			cfg_q.red_min        <= CH_W'(150);
			cfg_q.green_min      <= CH_W'(50);
			cfg_q.blue_min       <= CH_W'(0);
			cfg_q.red_max        <= CH_W'(255);
			cfg_q.green_max      <= CH_W'(233);
			cfg_q.blue_max       <= CH_W'(66);
			cfg_q.dark_limit     <= DARK_LIMIT_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_DARK_THR:  cfg_q.dark_threshold <= wr_data[CH_W-1:0];
				REG_RED_MIN:   cfg_q.red_min        <= wr_data[CH_W-1:0];
				REG_GREEN_MIN: cfg_q.green_min      <= wr_data[CH_W-1:0];
				REG_BLUE_MIN:  cfg_q.blue_min       <= wr_data[CH_W-1:0];
				REG_RED_MAX:   cfg_q.red_max        <= wr_data[CH_W-1:0];
				REG_GREEN_MAX: cfg_q.green_max      <= wr_data[CH_W-1:0];
				REG_BLUE_MAX:  cfg_q.blue_max       <= wr_data[CH_W-1:0];
				REG_DARK_LIM:  cfg_q.dark_limit     <= wr_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* sv/rgbfire_classify.sv */
// Pixel unpack (RGB555 to 8-bit channels) and dark / fire classification.
// Depends on rgbfire_pkg.
module rgbfire_classify
	import rgbfire_pkg::*;
(
	input  logic [CH_W-1:0] first_byte,
	input  logic [CH_W-1:0] second_byte,
	input  cfg_t            cfg,
	output cls_t            cls
);

	logic [CH_W-1:0] red, green, blue;
	logic            dark, fire;

	always_comb begin
		red   = {first_byte[6:2], 3'b000};
		green = {first_byte[1:0], second_byte[7:5], 3'b000};
		blue  = {second_byte[4:0], 3'b000};

		dark = (red < cfg.dark_threshold) && (green < cfg.dark_threshold) &&
		       (blue < cfg.dark_threshold);
		fire = (red > cfg.red_min) && (red < cfg.red_max) &&
		       (green > cfg.green_min) && (green < cfg.green_max) &&
		       (blue > cfg.blue_min) && (blue < cfg.blue_max);

		cls.red   = fire ? red : '1;
		cls.green = fire ? green : '1;
		cls.blue  = fire ? blue : '1;
		cls.fire  = fire;
		cls.dark  = dark;
	end

endmodule

/* sv/rgbfire_stats.sv */
// Per-frame saturating dark and fire counters with the unusable-frame test.
// Depends on rgbfire_pkg.
module rgbfire_stats
	import rgbfire_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic             dark,
	input  logic             fire,
	input  logic             last,
	input  logic [CNT_W-1:0] dark_limit,
	output stats_t           stats
);

	logic [CNT_W-1:0] dark_count_q, fire_count_q;
	logic [CNT_W-1:0] dark_next, fire_next;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
		return (c >= COUNT_MAX) ? COUNT_MAX : c + CNT_W'(1);
	endfunction

	always_comb begin
		dark_next = dark ? sat_inc(dark_count_q) : dark_count_q;
		fire_next = fire ? sat_inc(fire_count_q) : fire_count_q;
		stats.dark_total = dark_next;
		stats.fire_total = fire_next;
		stats.unusable   = last && (dark_next > dark_limit);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dark_count_q <= '0;
			fire_count_q <= '0;
		end else if (adv) begin
			dark_count_q <= last ? '0 : dark_next;
			fire_count_q <= last ? '0 : fire_next;
		end
	end

endmodule

/* sv/rgb555_fire_pixel_classifier_top.sv */
// Fire pixel classifier: input register, classify + counters, result register.
// Depends on rgbfire_pkg, rgbfire_cfg, rgbfire_classify, rgbfire_stats and the defines header.
// One pixel per clock while the result side does not stall: the input
// register feeds the unpack, compare and counter logic, which loads the result
// register. A stall on the result side backs up into in_stall only once both
// registers are full. Registers are written through the cfg port, always ready;
// write them only while no pixel is in flight. Per-frame counts advance as a
// pixel moves into the result register and clear after a pixel marked last.
`include "rgb555_fire_pixel_classifier_top_defines.svh"

module rgb555_fire_pixel_classifier_top
	import rgbfire_pkg::*;
#(
	parameter int FRAME_PIXELS = FRAME_PIXELS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [CH_W-1:0]       first_byte,
	input  logic [CH_W-1:0]       second_byte,
	input  logic                  last_pixel,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [CH_W-1:0]       red_out,
	output logic [CH_W-1:0]       green_out,
	output logic [CH_W-1:0]       blue_out,
	output logic                  is_fire,
	output logic                  is_dark,
	output logic                  frame_done,
	output logic [CNT_W-1:0]      dark_total,
	output logic [CNT_W-1:0]      fire_total,
	output logic                  frame_unusable,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t   cfg;
	cls_t   cls;
	stats_t stats;

	logic            valid_s1;
	logic [CH_W-1:0] first_s1, second_s1;
	logic            last_s1;

	logic             valid_s2;
	cls_t             cls_s2;
	logic             last_s2;
	stats_t           stats_s2;

	logic adv;

	assign cfg_ready = 1'b1;

	rgbfire_cfg #(
		.FRAME_PIXELS(FRAME_PIXELS)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cfg_valid && cfg_ready),
		.wr_index(cfg_index),
		.wr_data (cfg_data),
		.cfg     (cfg)
	);

	assign adv      = valid_s1 && !(valid_s2 && out_stall);
	assign in_stall = valid_s1 && valid_s2 && out_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			first_s1  <= first_byte;
			second_s1 <= second_byte;
			last_s1   <= last_pixel;
		end
	end

	rgbfire_classify u_classify (
		.first_byte (first_s1),
		.second_byte(second_s1),
		.cfg        (cfg),
		.cls        (cls)
	);

	rgbfire_stats u_stats (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.dark      (cls.dark),
		.fire      (cls.fire),
		.last      (last_s1),
		.dark_limit(cfg.dark_limit),
		.stats     (stats)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cls_s2   <= cls;
			last_s2  <= last_s1;
			stats_s2 <= stats;
		end
	end

	assign out_valid      = valid_s2;
	assign red_out        = cls_s2.red;
	assign green_out      = cls_s2.green;
	assign blue_out       = cls_s2.blue;
	assign is_fire        = cls_s2.fire;
	assign is_dark        = cls_s2.dark;
	assign frame_done     = last_s2;
	assign dark_total     = stats_s2.dark_total;
	assign fire_total     = stats_s2.fire_total;
	assign frame_unusable = stats_s2.unusable;

	`RGBF_ASSERT(a_full_stalls, valid_s1 && valid_s2 && out_stall |-> in_stall, "full pipe not stalled")
	`RGBF_ASSERT(a_unusable_at_end, out_valid && frame_unusable |-> frame_done, "unusable off frame end")
	`RGBF_ASSERT(a_dark_counted, out_valid && is_dark |-> dark_total != '0, "dark pixel not counted")
	`RGBF_ASSERT(a_count_sat, out_valid |-> dark_total <= COUNT_MAX && fire_total <= COUNT_MAX, "count past saturation")

endmodule

/* test/rgb555_fire_pixel_classifier_checker.sv */
`timescale 1ns / 100ps
// Result checker for rgb555_fire_pixel_classifier_top: tracks register writes,
// predicts the classification and frame totals of each pixel request and
// compares results in order. Depends on rgbfire_pkg.
module rgb555_fire_pixel_classifier_checker
	import rgbfire_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  logic [CH_W-1:0]       first_byte,
	input  logic [CH_W-1:0]       second_byte,
	input  logic                  last_pixel,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  logic [CH_W-1:0]       red_out,
	input  logic [CH_W-1:0]       green_out,
	input  logic [CH_W-1:0]       blue_out,
	input  logic                  is_fire,
	input  logic                  is_dark,
	input  logic                  frame_done,
	input  logic [CNT_W-1:0]      dark_total,
	input  logic [CNT_W-1:0]      fire_total,
	input  logic                  frame_unusable,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    mismatches,
	output int                    outstanding
);

	typedef struct packed {
		cls_t   pix;
		stats_t stats;
		logic   done;
	} pixel_res_t;

	cfg_t             regs;
	logic [CNT_W-1:0] dark_cnt;
	logic [CNT_W-1:0] fire_cnt;
	pixel_res_t       classified[$];
	int               errors = 0;

	function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] c);
		return (c >= COUNT_MAX) ? COUNT_MAX : c + CNT_W'(1);
	endfunction

	function automatic logic strictly_between(logic [CH_W-1:0] v, logic [CH_W-1:0] lo,
			logic [CH_W-1:0] hi);
		return (v > lo) && (v < hi);
	endfunction

	function automatic pixel_res_t classify_pixel(logic [CH_W-1:0] b1, logic [CH_W-1:0] b2,
			logic last);
		pixel_res_t      r;
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		red   = {b1[6:2], 3'b000};
		green = {b1[1:0], b2[7:5], 3'b000};
		blue  = {b2[4:0], 3'b000};
		r.pix.dark = (red < regs.dark_threshold) && (green < regs.dark_threshold) &&
			(blue < regs.dark_threshold);
		r.pix.fire = strictly_between(red, regs.red_min, regs.red_max) &&
			strictly_between(green, regs.green_min, regs.green_max) &&
			strictly_between(blue, regs.blue_min, regs.blue_max);
		if (r.pix.dark) dark_cnt = sat_inc(dark_cnt);
		if (r.pix.fire) fire_cnt = sat_inc(fire_cnt);
		r.pix.red   = r.pix.fire ? red : 8'hFF;
		r.pix.green = r.pix.fire ? green : 8'hFF;
		r.pix.blue  = r.pix.fire ? blue : 8'hFF;
		r.done = last;
		r.stats.dark_total = dark_cnt;
		r.stats.fire_total = fire_cnt;
		r.stats.unusable = last && (dark_cnt > regs.dark_limit);
		if (last) begin
			dark_cnt = '0;
			fire_cnt = '0;
		end
		return r;
	endfunction

	task automatic check_field(string what, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		pixel_res_t want;
		if (!arst_n) begin
			regs = '{dark_threshold: 8'd27, red_min: 8'd150, green_min: 8'd50,
				blue_min: 8'd0, red_max: 8'd255, green_max: 8'd233, blue_max: 8'd66,
				dark_limit: CNT_W'(FRAME_PIXELS_DEF * 2 / 5)};
			dark_cnt = '0;
			fire_cnt = '0;
			classified.delete();
			outstanding <= 0;
			mismatches <= errors;
		end else begin
			if (out_valid && !out_stall) begin
				if (classified.size() == 0) begin
					errors++;
					$display("%0t: result with no pending request", $time);
				end else begin
					want = classified.pop_front();
					check_field("red_out", CNT_W'(want.pix.red), CNT_W'(red_out));
					check_field("green_out", CNT_W'(want.pix.green), CNT_W'(green_out));
					check_field("blue_out", CNT_W'(want.pix.blue), CNT_W'(blue_out));
					check_field("is_fire", CNT_W'(want.pix.fire), CNT_W'(is_fire));
					check_field("is_dark", CNT_W'(want.pix.dark), CNT_W'(is_dark));
					check_field("frame_done", CNT_W'(want.done), CNT_W'(frame_done));
					check_field("dark_total", want.stats.dark_total, dark_total);
					check_field("fire_total", want.stats.fire_total, fire_total);
					check_field("frame_unusable", CNT_W'(want.stats.unusable),
						CNT_W'(frame_unusable));
				end
			end
			if (in_valid && !in_stall)
				classified.push_back(classify_pixel(first_byte, second_byte, last_pixel));
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_DARK_THR:  regs.dark_threshold = cfg_data[CH_W-1:0];
					REG_RED_MIN:   regs.red_min = cfg_data[CH_W-1:0];
					REG_GREEN_MIN: regs.green_min = cfg_data[CH_W-1:0];
					REG_BLUE_MIN:  regs.blue_min = cfg_data[CH_W-1:0];
					REG_RED_MAX:   regs.red_max = cfg_data[CH_W-1:0];
					REG_GREEN_MAX: regs.green_max = cfg_data[CH_W-1:0];
					REG_BLUE_MAX:  regs.blue_max = cfg_data[CH_W-1:0];
					REG_DARK_LIM:  regs.dark_limit = cfg_data[CNT_W-1:0];
					default: ;
				endcase
			end
			outstanding <= classified.size();
			mismatches <= errors;
		end
	end

endmodule

/* test/rgb555_fire_pixel_classifier_top_tb.sv */
`timescale 1ns / 100ps
// Testbench top for rgb555_fire_pixel_classifier_top: drives pixel requests,
// register writes and result stalls, and gives the verdict.
// Depends on rgbfire_pkg and rgb555_fire_pixel_classifier_checker.
module rgb555_fire_pixel_classifier_top_tb;
	import rgbfire_pkg::*;

	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASES         = 11;
	localparam int PHASE_PIXELS   = 103;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic [CH_W-1:0]       first_byte;
	logic [CH_W-1:0]       second_byte;
	logic                  last_pixel;
	logic                  out_valid;
	logic                  out_stall;
	logic [CH_W-1:0]       red_out;
	logic [CH_W-1:0]       green_out;
	logic [CH_W-1:0]       blue_out;
	logic                  is_fire;
	logic                  is_dark;
	logic                  frame_done;
	logic [CNT_W-1:0]      dark_total;
	logic [CNT_W-1:0]      fire_total;
	logic                  frame_unusable;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int   mismatches;
	int   outstanding;
	bit   in_gaps;
	bit   out_gaps;
	bit   hold_off;
	cfg_t shadow;

	always #5 clk = ~clk;

	rgb555_fire_pixel_classifier_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.first_byte(first_byte), .second_byte(second_byte), .last_pixel(last_pixel),
		.out_valid(out_valid), .out_stall(out_stall),
		.red_out(red_out), .green_out(green_out), .blue_out(blue_out),
		.is_fire(is_fire), .is_dark(is_dark), .frame_done(frame_done),
		.dark_total(dark_total), .fire_total(fire_total), .frame_unusable(frame_unusable),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	rgb555_fire_pixel_classifier_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.first_byte(first_byte), .second_byte(second_byte), .last_pixel(last_pixel),
		.out_valid(out_valid), .out_stall(out_stall),
		.red_out(red_out), .green_out(green_out), .blue_out(blue_out),
		.is_fire(is_fire), .is_dark(is_dark), .frame_done(frame_done),
		.dark_total(dark_total), .fire_total(fire_total), .frame_unusable(frame_unusable),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.mismatches(mismatches), .outstanding(outstanding)
	);

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [4:0] near(logic [CH_W-1:0] lo, logic [CH_W-1:0] hi);
		return 5'($urandom_range(lo >> 3, hi >> 3));
	endfunction

	function automatic cfg_t random_config();
		cfg_t c;
		int   k;
		c.dark_threshold = CH_W'($urandom_range(0, 255));
		c.red_min   = CH_W'($urandom_range(0, 220));
		c.red_max   = CH_W'($urandom_range(c.red_min, 255));
		c.green_min = CH_W'($urandom_range(0, 220));
		c.green_max = CH_W'($urandom_range(c.green_min, 255));
		c.blue_min  = CH_W'($urandom_range(0, 220));
		c.blue_max  = CH_W'($urandom_range(c.blue_min, 255));
		if ($urandom_range(0, 5) == 0) c.green_max = c.green_min;
		k = $urandom_range(0, 7);
		if (k == 0) c.dark_limit = COUNT_MAX;
		else if (k == 1) c.dark_limit = CNT_W'($urandom_range(0, COUNT_MAX));
		else c.dark_limit = CNT_W'($urandom_range(0, 10));
		return c;
	endfunction

	task automatic send_pixel(logic [CH_W-1:0] b1, logic [CH_W-1:0] b2, logic last);
		int gap;
		gap = in_gaps ? pick_gap() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		first_byte <= b1;
		second_byte <= b2;
		last_pixel <= last;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic send_rgb(logic [4:0] r5, logic [4:0] g5, logic [4:0] b5, logic last);
		send_pixel({1'($urandom), r5, g5[4:3]}, {g5[2:0], b5}, last);
	endtask

	task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Upper bits of the 8-bit registers carry junk; one write to an unused index.
	task automatic load_config(cfg_t c);
		set_reg(REG_DARK_THR, {13'($urandom), c.dark_threshold});
		set_reg(REG_RED_MIN, {13'($urandom), c.red_min});
		set_reg(REG_GREEN_MIN, {13'($urandom), c.green_min});
		set_reg(REG_BLUE_MIN, {13'($urandom), c.blue_min});
		set_reg(REG_RED_MAX, {13'($urandom), c.red_max});
		set_reg(REG_GREEN_MAX, {13'($urandom), c.green_max});
		set_reg(REG_BLUE_MAX, {13'($urandom), c.blue_max});
		set_reg(REG_DARK_LIM, c.dark_limit);
		set_reg(CFG_IDX_W'($urandom_range(REG_DARK_LIM + 1, 2 ** CFG_IDX_W - 1)),
			CFG_DATA_W'($urandom));
		cfg_valid <= 1'b0;
		shadow = c;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic send_frames(int count);
		int frame_len;
		int kind;
		frame_len = 0;
		for (int i = 0; i < count; i++) begin
			if (frame_len == 0)
				frame_len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 60)
					: $urandom_range(1, 16);
			kind = $urandom_range(0, 9);
			if (kind < 4)
				send_rgb(near(shadow.red_min, shadow.red_max),
					near(shadow.green_min, shadow.green_max),
					near(shadow.blue_min, shadow.blue_max), frame_len == 1);
			else if (kind < 6)
				send_rgb(near(0, shadow.dark_threshold), near(0, shadow.dark_threshold),
					near(0, shadow.dark_threshold), frame_len == 1);
			else
				send_pixel(8'($urandom), 8'($urandom), frame_len == 1);
			frame_len--;
		end
	endtask

	// Receiver: random stalls, plus one long hold-off on request.
	initial begin : receiver
		int run_len;
		int stall_len;
		out_stall <= 1'b0;
		forever begin
			if (hold_off) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off = 1'b0;
			end
			run_len = $urandom_range(1, 20);
			out_stall <= 1'b0;
			repeat (run_len) @(posedge clk);
			stall_len = out_gaps ? pick_gap() : 0;
			if (stall_len > 0) begin
				out_stall <= 1'b1;
				repeat (stall_len) @(posedge clk);
			end
		end
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				idle = 0;
			else
				idle++;
		end
		$display("%0t: no request accepted for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("rgb555_fire_pixel_classifier_top_tb: FAIL");
		$finish;
	end

	initial begin : stimulus
		cfg_t c;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		first_byte <= '0;
		second_byte <= '0;
		last_pixel <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_gaps = 1'b1;
		out_gaps = 1'b1;
		hold_off = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset bounds: dark below 27, fire strictly inside red 150..255, green 50..233, blue 0..66
		send_rgb(5'd0, 5'd0, 5'd0, 1'b0);
		send_rgb(5'd31, 5'd31, 5'd31, 1'b0);
		send_pixel(8'h80, 8'h00, 1'b0);
		send_rgb(5'd19, 5'd7, 5'd1, 1'b0);
		send_rgb(5'd31, 5'd29, 5'd8, 1'b0);
		send_rgb(5'd18, 5'd7, 5'd1, 1'b0);
		send_rgb(5'd19, 5'd6, 5'd1, 1'b0);
		send_rgb(5'd19, 5'd7, 5'd0, 1'b0);
		send_rgb(5'd19, 5'd7, 5'd9, 1'b0);
		send_rgb(5'd3, 5'd3, 5'd3, 1'b0);
		send_rgb(5'd4, 5'd3, 5'd3, 1'b0);
		send_rgb(5'd19, 5'd30, 5'd1, 1'b0);
		send_rgb(5'd0, 5'd0, 5'd0, 1'b1);
		send_rgb(5'd25, 5'd13, 5'd4, 1'b1);
		drain();

		// everything dark, widest bounds, zero dark limit
		c = '{dark_threshold: 8'd255, red_min: 8'd0, green_min: 8'd0, blue_min: 8'd0,
			red_max: 8'd255, green_max: 8'd255, blue_max: 8'd255, dark_limit: '0};
		load_config(c);
		send_rgb(5'd0, 5'd0, 5'd0, 1'b1);
		send_rgb(5'd31, 5'd31, 5'd31, 1'b0);
		send_rgb(5'd1, 5'd1, 5'd1, 1'b1);
		drain();

		// nothing dark, empty bounds, top dark limit
		c = '{dark_threshold: 8'd0, red_min: 8'd255, green_min: 8'd255, blue_min: 8'd255,
			red_max: 8'd0, green_max: 8'd0, blue_max: 8'd0, dark_limit: COUNT_MAX};
		load_config(c);
		send_rgb(5'd0, 5'd0, 5'd0, 1'b0);
		send_rgb(5'd31, 5'd31, 5'd31, 1'b1);
		drain();

		for (int p = 0; p < PHASES; p++) begin
			load_config(random_config());
			in_gaps = ($urandom_range(0, 3) != 0);
			out_gaps = ($urandom_range(0, 3) != 0);
			if (p == 4) begin
				in_gaps = 1'b0;
				hold_off = 1'b1;
			end
			send_frames(PHASE_PIXELS);
			drain();
		end

		if (mismatches == 0)
			$display("rgb555_fire_pixel_classifier_top_tb: PASS");
		else
			$display("rgb555_fire_pixel_classifier_top_tb: FAIL");
		$finish;
	end

endmodule
